// File: sv/utf8e_pkg.sv
// ---------------------------------------------------------------------------
// utf8e_pkg: shared types and helpers for the UTF-8 stream encoder
// Register indexes, status codes, count widths and the per-point encoding.
// ---------------------------------------------------------------------------
package utf8e_pkg;

   localparam int COUNT_BITS = 16;
   // Width used for the budget comparison: large enough for the count and
   // for the 16-bit budget.
   localparam int CMP_BITS   = (COUNT_BITS > 16) ? COUNT_BITS : 16;

   localparam logic [1:0] CSR_UNIT_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_BYTE_BUDGET = 2'd1;

   localparam logic [1:0] UNIT_8BIT  = 2'd0;
   localparam logic [1:0] UNIT_16BIT = 2'd1;

   localparam logic [7:0]  LEAD_2B   = 8'hC0;
   localparam logic [7:0]  LEAD_3B   = 8'hE0;
   localparam logic [7:0]  LEAD_4B   = 8'hF0;
   localparam logic [7:0]  CONT_LEAD = 8'h80;
   localparam logic [31:0] MAX_1B    = 32'h0000_007F;
   localparam logic [31:0] MAX_2B    = 32'h0000_07FF;
   localparam logic [31:0] MAX_3B    = 32'h0000_FFFF;
   localparam logic [31:0] MAX_4B    = 32'h001F_FFFF;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_BUDGET = 2'd1,
      STATUS_RANGE  = 2'd2
   } status_type;

   typedef logic [COUNT_BITS-1:0] count_type;

   typedef struct packed {
      logic [3:0][7:0] bytes;    // bytes[0] is sent first
      logic [1:0]      last_idx; // number of bytes minus one
   } enc_type;

   function automatic logic [31:0] mask_unit(input logic [31:0] cp,
                                             input logic [1:0]  width);
      logic [31:0] res;
      case (width)
         UNIT_8BIT:  res = {24'd0, cp[7:0]};
         UNIT_16BIT: res = {16'd0, cp[15:0]};
         default:    res = cp;
      endcase
      return res;
   endfunction

   // Valid only for points up to MAX_4B.
   function automatic enc_type encode(input logic [31:0] cp);
      enc_type e;
      e.bytes = '0;
      if (cp <= MAX_1B) begin
         e.last_idx = 2'd0;
         e.bytes[0] = cp[7:0];
      end else if (cp <= MAX_2B) begin
         e.last_idx = 2'd1;
         e.bytes[0] = LEAD_2B | {3'd0, cp[10:6]};
         e.bytes[1] = CONT_LEAD | {2'd0, cp[5:0]};
      end else if (cp <= MAX_3B) begin
         e.last_idx = 2'd2;
         e.bytes[0] = LEAD_3B | {4'd0, cp[15:12]};
         e.bytes[1] = CONT_LEAD | {2'd0, cp[11:6]};
         e.bytes[2] = CONT_LEAD | {2'd0, cp[5:0]};
      end else begin
         e.last_idx = 2'd3;
         e.bytes[0] = LEAD_4B | {5'd0, cp[20:18]};
         e.bytes[1] = CONT_LEAD | {2'd0, cp[17:12]};
         e.bytes[2] = CONT_LEAD | {2'd0, cp[11:6]};
         e.bytes[3] = CONT_LEAD | {2'd0, cp[5:0]};
      end
      return e;
   endfunction

endpackage

// File: sv/utf8_stream_encoder.sv
// ---------------------------------------------------------------------------
// utf8_stream_encoder: code point to UTF-8 byte stream with byte budget
// Masks each code unit, encodes it in one to four bytes, tracks per-call
// byte and point counts and halts the call on a range or budget error.
// ---------------------------------------------------------------------------
//  Channel  Direction  Handshake              Payload
//  req      in         req_valid/req_ready    code_unit, start_of_call,
//                                             last_in_call
//  rsp      out        rsp_valid/rsp_ready    out_byte, byte_valid, last_of_run,
//                                             status, call_done, bytes_so_far,
//                                             points_so_far, current_point
//  csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// An accepted word sits in an input register; the encoder moves it into the
// output run register, where its bytes leave one per cycle while rsp_ready is
// high. A point yields one word per byte on the single output byte port, or
// one word for an error result; a dropped word of a halted call yields none.
// The input register refills while the run register still drains, so items
// flow with no idle cycle. Reset empties both registers and clears the counts.
// ---------------------------------------------------------------------------
module utf8_stream_encoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_code_unit,
   input  logic        req_start_of_call,
   input  logic        req_last_in_call,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_byte_valid,
   output logic        rsp_last_of_run,
   output logic [1:0]  rsp_status,
   output logic        rsp_call_done,
   output logic [15:0] rsp_bytes_so_far,
   output logic [15:0] rsp_points_so_far,
   output logic [31:0] rsp_current_point,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import utf8e_pkg::*;

   // Configuration
   logic [1:0]  unit_width_ff;
   logic [15:0] byte_budget_ff;

   // Input register
   logic        in_valid_ff;
   logic [31:0] in_cp_ff;
   logic        in_start_ff;
   logic        in_last_ff;

   // Call state
   count_type   bytes_used_ff, bytes_used_in;
   count_type   points_done_ff, points_done_in;
   logic        halted_ff, halted_in;

   // Run register
   logic        run_valid_ff;
   enc_type     run_enc_ff;
   logic [1:0]  run_idx_ff;
   logic        run_data_ff;
   status_type  run_status_ff;
   logic        run_last_ff;
   count_type   run_base_ff;
   count_type   run_points_ff;
   logic [31:0] run_cp_ff;

   // Processing of the held word
   logic [31:0]         cp_masked;
   enc_type             enc;
   count_type           used_eff;
   count_type           points_eff;
   logic                halted_eff;
   logic                range_err;
   logic                budget_err;
   logic [2:0]          nbytes;
   logic [CMP_BITS:0]   need;
   status_type          status_in;
   logic                run_done;
   logic                advance;
   logic                load_run;
   count_type           byte_count;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_width_ff  <= 2'd2;
         byte_budget_ff <= 16'hFFFF;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_UNIT_WIDTH:  unit_width_ff  <= csr_data[1:0];
            CSR_BYTE_BUDGET: byte_budget_ff <= csr_data;
            default:         ;
         endcase
      end
   end

   always_comb begin
      cp_masked  = mask_unit(in_cp_ff, unit_width_ff);
      enc        = encode(cp_masked);
      used_eff   = in_start_ff ? '0 : bytes_used_ff;
      points_eff = in_start_ff ? '0 : points_done_ff;
      halted_eff = in_start_ff ? 1'b0 : halted_ff;
      nbytes     = {1'b0, enc.last_idx} + 3'd1;
      range_err  = cp_masked > MAX_4B;
      // Short of budget exactly when the used count plus this point's bytes
      // goes past the budget.
      need       = {1'b0, CMP_BITS'(used_eff)} + (CMP_BITS+1)'(nbytes);
      budget_err = need > (CMP_BITS+1)'(byte_budget_ff);
      if (range_err) begin
         status_in = STATUS_RANGE;
      end else if (budget_err) begin
         status_in = STATUS_BUDGET;
      end else begin
         status_in = STATUS_OK;
      end
   end

   assign run_done  = run_valid_ff && rsp_ready && rsp_last_of_run;
   assign advance   = in_valid_ff && (halted_eff || !run_valid_ff || run_done);
   assign load_run  = advance && !halted_eff;
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      bytes_used_in  = bytes_used_ff;
      points_done_in = points_done_ff;
      halted_in      = halted_ff;
      if (advance) begin
         bytes_used_in  = used_eff;
         points_done_in = points_eff;
         halted_in      = halted_eff;
         if (!halted_eff) begin
            if (status_in != STATUS_OK) begin
               halted_in = 1'b1;
            end else begin
               bytes_used_in  = used_eff + COUNT_BITS'(nbytes);
               points_done_in = points_eff + COUNT_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_used_ff  <= '0;
         points_done_ff <= '0;
         halted_ff      <= 1'b0;
      end else begin
         bytes_used_ff  <= bytes_used_in;
         points_done_ff <= points_done_in;
         halted_ff      <= halted_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_cp_ff    <= req_code_unit;
         in_start_ff <= req_start_of_call;
         in_last_ff  <= req_last_in_call;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_valid_ff <= 1'b0;
         run_idx_ff   <= 2'd0;
      end else if (load_run) begin
         run_valid_ff <= 1'b1;
         run_idx_ff   <= 2'd0;
      end else if (run_done) begin
         run_valid_ff <= 1'b0;
      end else if (run_valid_ff && rsp_ready) begin
         run_idx_ff <= run_idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load_run) begin
         run_enc_ff.bytes <= enc.bytes;
         // An error result is a single word.
         run_enc_ff.last_idx <= (status_in == STATUS_OK) ? enc.last_idx : 2'd0;
         run_data_ff   <= (status_in == STATUS_OK);
         run_status_ff <= status_in;
         run_last_ff   <= in_last_ff;
         run_base_ff   <= used_eff;
         run_points_ff <= points_eff;
         run_cp_ff     <= cp_masked;
      end
   end

   assign byte_count = run_data_ff
                       ? run_base_ff + COUNT_BITS'(run_idx_ff) + COUNT_BITS'(1)
                       : run_base_ff;

   assign rsp_valid         = run_valid_ff;
   assign rsp_out_byte      = run_data_ff ? run_enc_ff.bytes[run_idx_ff] : 8'd0;
   assign rsp_byte_valid    = run_data_ff;
   assign rsp_last_of_run   = (run_idx_ff == run_enc_ff.last_idx);
   assign rsp_status        = run_status_ff;
   assign rsp_call_done     = !run_data_ff || (rsp_last_of_run && run_last_ff);
   assign rsp_bytes_so_far  = 16'(byte_count);
   assign rsp_points_so_far = 16'(run_points_ff);
   assign rsp_current_point = run_cp_ff;

endmodule

// File: sim/testbench.sv
// ---------------------------------------------------------------------------
// testbench: self-checking bench for the UTF-8 stream encoder
// A scoreboard object predicts the byte words of every accepted code point
// and checks each result word in order. Directed points cover the range
// edges, masking, range and budget errors and halted calls. Random calls
// follow under varying idle levels, and one long call fills the budget.
// ---------------------------------------------------------------------------
import utf8e_pkg::*;

typedef struct packed {
   logic [7:0]  data;
   logic        data_ok;
   logic        run_end;
   status_type  status;
   logic        call_end;
   logic [15:0] nbytes;
   logic [15:0] npoints;
   logic [31:0] point;
} out_word_type;

class utf8_scoreboard;
   logic [1:0]   unit_width;
   logic [15:0]  budget;
   count_type    bytes_used;
   count_type    points_done;
   bit           halted;
   out_word_type expected_q[$];
   int           errors;

   function new();
      unit_width  = 2'd2;
      budget      = 16'hFFFF;
      bytes_used  = '0;
      points_done = '0;
      halted      = 1'b0;
      errors      = 0;
   endfunction

   function void set_register(input logic [1:0] idx, input logic [15:0] data);
      if (idx == CSR_UNIT_WIDTH) begin
         unit_width = data[1:0];
      end else if (idx == CSR_BYTE_BUDGET) begin
         budget = data;
      end
   endfunction

   function int pending();
      return expected_q.size();
   endfunction

   function void flush();
      expected_q.delete();
   endfunction

   task report(input string msg);
      errors++;
      $display("mismatch: %s", msg);
   endtask

   // Predicts the words caused by one accepted code unit; returns their number.
   function int note_word(input logic [31:0] raw, input logic is_start,
                          input logic is_last);
      logic [31:0]  p;
      logic [31:0]  rest;
      logic [7:0]   enc [4];
      int unsigned  n;
      int unsigned  left;
      int           k;
      out_word_type w;
      if (is_start) begin
         bytes_used  = '0;
         points_done = '0;
         halted      = 1'b0;
      end
      if (halted) return 0;
      case (unit_width)
         UNIT_8BIT:  p = raw & 32'h0000_00FF;
         UNIT_16BIT: p = raw & 32'h0000_FFFF;
         default:    p = raw;
      endcase
      w.data     = '0;
      w.data_ok  = 1'b0;
      w.run_end  = 1'b1;
      w.call_end = 1'b1;
      w.nbytes   = 16'(bytes_used);
      w.npoints  = 16'(points_done);
      w.point    = p;
      if (p > MAX_4B) begin
         halted   = 1'b1;
         w.status = STATUS_RANGE;
         expected_q.push_back(w);
         return 1;
      end
      n = (p <= MAX_1B) ? 1 : (p <= MAX_2B) ? 2 : (p <= MAX_3B) ? 3 : 4;
      left = (bytes_used < budget) ? (int'(budget) - int'(bytes_used)) : 0;
      if (left < n) begin
         halted   = 1'b1;
         w.status = STATUS_BUDGET;
         expected_q.push_back(w);
         return 1;
      end
      // Continuation bytes take six bits each from the tail; what is left
      // fits the payload bits of the lead byte.
      rest = p;
      for (k = n - 1; k > 0; k--) begin
         enc[k] = CONT_LEAD | {2'b00, rest[5:0]};
         rest   = rest >> 6;
      end
      case (n)
         1:       enc[0] = rest[7:0];
         2:       enc[0] = LEAD_2B | rest[7:0];
         3:       enc[0] = LEAD_3B | rest[7:0];
         default: enc[0] = LEAD_4B | rest[7:0];
      endcase
      for (k = 0; k < n; k++) begin
         bytes_used = bytes_used + 1'b1;
         w.data     = enc[k];
         w.data_ok  = 1'b1;
         w.run_end  = (k == n - 1);
         w.status   = STATUS_OK;
         w.call_end = (k == n - 1) && is_last;
         w.nbytes   = 16'(bytes_used);
         expected_q.push_back(w);
      end
      points_done = points_done + 1'b1;
      return n;
   endfunction

   task check_result(input out_word_type got);
      out_word_type exp;
      if (expected_q.size() == 0) begin
         report($sformatf("result word %h with nothing expected", got));
         return;
      end
      exp = expected_q.pop_front();
      if (got.data !== exp.data || got.data_ok !== exp.data_ok ||
          got.run_end !== exp.run_end || got.status !== exp.status ||
          got.call_end !== exp.call_end || got.nbytes !== exp.nbytes ||
          got.npoints !== exp.npoints || got.point !== exp.point) begin
         report({$sformatf("point %h: got byte %h v%b l%b st%0d d%b n%0d p%0d",
                           exp.point, got.data, got.data_ok, got.run_end,
                           got.status, got.call_end, got.nbytes, got.npoints),
                 $sformatf(", exp byte %h v%b l%b st%0d d%b n%0d p%0d",
                           exp.data, exp.data_ok, exp.run_end, exp.status,
                           exp.call_end, exp.nbytes, exp.npoints)});
         if (got.point !== exp.point) begin
            report($sformatf("current point %h, expected %h", got.point, exp.point));
         end
      end
   endtask
endclass

module testbench;

   localparam logic [1:0] UNIT_32BIT   = 2'd2;
   localparam logic [1:0] UNIT_RAW     = 2'd3;
   localparam int         DRAIN_CYCLES = 12;
   localparam int         HOLD_CYCLES  = 300;
   localparam logic [31:0] BOUNDARY_POINTS [12] = '{
      32'h0000_0000, 32'h0000_007F, 32'h0000_0080, 32'h0000_07FF,
      32'h0000_0800, 32'h0000_D800, 32'h0000_DFFF, 32'h0000_FFFF,
      32'h0001_0000, 32'h001F_FFFF, 32'h0020_0000, 32'hFFFF_FFFF};

   logic        clock             = 1'b0;
   logic        reset             = 1'b1;
   logic        req_valid         = 1'b0;
   logic        req_ready;
   logic [31:0] req_code_unit     = '0;
   logic        req_start_of_call = 1'b0;
   logic        req_last_in_call  = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready         = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_byte_valid;
   logic        rsp_last_of_run;
   logic [1:0]  rsp_status;
   logic        rsp_call_done;
   logic [15:0] rsp_bytes_so_far;
   logic [15:0] rsp_points_so_far;
   logic [31:0] rsp_current_point;
   logic        csr_valid         = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index         = '0;
   logic [15:0] csr_data          = '0;

   utf8_scoreboard sb;
   int   tx_idle_pct = 0;
   int   rx_idle_pct = 0;
   int   produced    = 0;
   bit   hold_go     = 1'b0;
   logic rx_hold     = 1'b0;

   utf8_stream_encoder u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_code_unit     (req_code_unit),
      .req_start_of_call (req_start_of_call),
      .req_last_in_call  (req_last_in_call),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_byte_valid    (rsp_byte_valid),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_status        (rsp_status),
      .rsp_call_done     (rsp_call_done),
      .rsp_bytes_so_far  (rsp_bytes_so_far),
      .rsp_points_so_far (rsp_points_so_far),
      .rsp_current_point (rsp_current_point),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
   end

   // One long receiver stall while the sender keeps offering words.
   initial begin
      wait (hold_go);
      @(posedge clock);
      rx_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rx_hold <= 1'b0;
   end

   always @(posedge clock) begin : result_monitor
      out_word_type seen;
      if (!reset && rsp_valid && rsp_ready) begin
         seen.data     = rsp_out_byte;
         seen.data_ok  = rsp_byte_valid;
         seen.run_end  = rsp_last_of_run;
         seen.status   = status_type'(rsp_status);
         seen.call_end = rsp_call_done;
         seen.nbytes   = rsp_bytes_so_far;
         seen.npoints  = rsp_points_so_far;
         seen.point    = rsp_current_point;
         sb.check_result(seen);
      end
   end

   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic logic [31:0] rand_point();
      case ($urandom_range(0, 11))
         0, 1:    return $urandom_range(32'h7F, 0);
         2:       return $urandom_range(32'h7FF, 32'h80);
         3:       return $urandom_range(32'hFFFF, 32'h800);
         4:       return $urandom_range(32'h1F_FFFF, 32'h1_0000);
         5:       return $urandom_range(32'hFFFF_FFFF, 32'h20_0000);
         6:       return $urandom;
         // Junk in the upper bits exercises the unit width mask.
         7:       return {16'($urandom), 16'($urandom_range(16'h7FF, 0))};
         8:       return {24'($urandom), 8'($urandom)};
         default: return BOUNDARY_POINTS[$urandom_range(0, 11)];
      endcase
   endfunction

   task automatic send_word(input logic [31:0] cp, input logic is_start,
                            input logic is_last);
      int gap;
      gap = ($urandom_range(0, 99) < tx_idle_pct) ? $urandom_range(1, 5) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_code_unit     <= cp;
      req_start_of_call <= is_start;
      req_last_in_call  <= is_last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      produced = sb.note_word(cp, is_start, is_last);
   endtask

   task automatic apply_config(input logic [15:0] width_word,
                               input logic [15:0] budget_word);
      csr_valid <= 1'b1;
      csr_index <= CSR_UNIT_WIDTH;
      csr_data  <= width_word;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_register(CSR_UNIT_WIDTH, width_word);
      csr_index <= CSR_BYTE_BUDGET;
      csr_data  <= budget_word;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_register(CSR_BYTE_BUDGET, budget_word);
      csr_valid <= 1'b0;
   endtask

   // A dropped word gives no result, so the block may still be busy when the
   // queue runs empty; the trailing DRAIN_CYCLES wait covers that.
   task automatic wait_drained();
      int guard;
      req_valid <= 1'b0;
      guard = 0;
      while (sb.pending() != 0 && guard < 50000) begin
         @(posedge clock);
         guard++;
      end
      if (sb.pending() != 0) begin
         sb.report($sformatf("%0d expected words never arrived", sb.pending()));
         sb.flush();
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic apply_random_config();
      logic [15:0] budget_word;
      case ($urandom_range(0, 3))
         0:       budget_word = $urandom_range(12, 0);
         1:       budget_word = $urandom_range(60, 13);
         2:       budget_word = 16'hFFFF;
         default: budget_word = $urandom_range(16'hFFFF, 0);
      endcase
      apply_config({14'($urandom), 2'($urandom_range(3, 0))}, budget_word);
   endtask

   task automatic directed_part();
      apply_config({14'd0, UNIT_32BIT}, 16'hFFFF);
      send_word(32'h0000_0000, 1'b1, 1'b0);
      send_word(32'h0000_007F, 1'b0, 1'b0);
      send_word(32'h0000_0080, 1'b0, 1'b0);
      send_word(32'h0000_07FF, 1'b0, 1'b0);
      send_word(32'h0000_0800, 1'b0, 1'b0);
      send_word(32'h0000_D800, 1'b0, 1'b0);   // surrogates encode normally
      send_word(32'h0000_FFFF, 1'b0, 1'b0);
      send_word(32'h0001_0000, 1'b0, 1'b0);
      send_word(32'h001F_FFFF, 1'b0, 1'b1);
      // Counts carry on past the end of a call when no start follows.
      send_word(32'h0000_0041, 1'b0, 1'b0);
      send_word(32'h0020_0000, 1'b0, 1'b0);
      send_word(32'h0000_0042, 1'b0, 1'b0);   // dropped, call is halted
      send_word(32'hFFFF_FFFF, 1'b1, 1'b0);
      send_word(32'h0000_0043, 1'b1, 1'b1);
      wait_drained();
      apply_config({14'd0, UNIT_8BIT}, 16'hFFFF);
      send_word(32'hFFFF_FF80, 1'b1, 1'b0);
      send_word(32'h1234_56FF, 1'b0, 1'b1);
      wait_drained();
      apply_config({14'd0, UNIT_16BIT}, 16'hFFFF);
      send_word(32'hABCD_FFFF, 1'b1, 1'b1);
      wait_drained();
      // Width three applies no mask at all.
      apply_config({14'd0, UNIT_RAW}, 16'hFFFF);
      send_word(32'h1234_5678, 1'b1, 1'b0);
      send_word(32'h0000_1234, 1'b1, 1'b1);
      wait_drained();
      apply_config({14'd0, UNIT_32BIT}, 16'h0000);
      send_word(32'h0000_0000, 1'b1, 1'b1);
      wait_drained();
      apply_config({14'd0, UNIT_32BIT}, 16'd5);
      send_word(32'h0000_0800, 1'b1, 1'b0);
      send_word(32'h0000_0801, 1'b0, 1'b1);
      wait_drained();
      // Lowering the budget below the bytes already used leaves nothing.
      apply_config({14'd0, UNIT_32BIT}, 16'hFFFF);
      send_word(32'h0001_0000, 1'b1, 1'b0);
      send_word(32'h0000_0020, 1'b0, 1'b0);
      wait_drained();
      apply_config({14'd0, UNIT_32BIT}, 16'd2);
      send_word(32'h0000_0021, 1'b0, 1'b1);
      wait_drained();
   endtask

   task automatic random_part(input int target);
      int live;
      int in_setting;
      int len;
      int k;
      live       = 0;
      in_setting = 0;
      wait_drained();
      apply_random_config();
      while (live < target) begin
         if (in_setting >= 25) begin
            wait_drained();
            apply_random_config();
            in_setting = 0;
         end
         if ($urandom_range(0, 99) < 80) begin
            len = $urandom_range(1, 8);
            for (k = 0; k < len; k++) begin
               send_word(rand_point(), k == 0, k == len - 1);
               live++;
               if (produced > 0) begin
                  in_setting++;
               end
            end
         end else begin
            len = $urandom_range(1, 3);
            for (k = 0; k < len; k++) begin
               send_word(rand_point(), 1'($urandom), 1'($urandom));
               live++;
               if (produced > 0) begin
                  in_setting++;
               end
            end
         end
      end
   endtask

   // One call that uses the whole budget, then runs out by a single byte.
   task automatic fill_budget();
      int k;
      wait_drained();
      apply_config({14'd0, UNIT_32BIT}, 16'd39);
      send_word($urandom_range(32'h1F_FFFF, 32'h1_0000), 1'b1, 1'b0);
      for (k = 0; k < 8; k++) begin
         send_word($urandom_range(32'h1F_FFFF, 32'h1_0000), 1'b0, 1'b0);
      end
      send_word($urandom_range(32'hFFFF, 32'h800), 1'b0, 1'b0);
      send_word(32'h0000_0041, 1'b0, 1'b1);
      send_word(32'h0000_007F, 1'b1, 1'b1);
   endtask

   initial begin : stimulus
      sb = new();
      tx_idle_pct = 8;
      rx_idle_pct = 81;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed_part();
      hold_go = 1'b1;
      random_part(90);
      tx_idle_pct = 81;
      rx_idle_pct = 8;
      random_part(90);
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      random_part(90);
      fill_budget();
      wait_drained();
      if (sb.errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// File: filelist.f
sv/utf8e_pkg.sv
sv/utf8_stream_encoder.sv
sim/testbench.sv
